/* sv/lgf_pkg.sv */
// Shared types, constants and frame-byte helpers for the level gauge frame encoder.
// No dependencies; imported by every module of the block.
package lgf_pkg;

    localparam int COLOUR_COUNT = 7;
    localparam int COLOUR_W     = 3;
    localparam int MASK_W       = 3;

    // level = sample*100/255 crosses 33, 66 and 100 at these sample values
    localparam logic [7:0] LIT0_MIN = 8'd85;
    localparam logic [7:0] LIT1_MIN = 8'd169;
    localparam logic [7:0] LIT2_MIN = 8'd255;

    localparam int START_BYTES   = 4;
    localparam int LED_COUNT     = 3;
    localparam int BYTES_PER_LED = 4;
    localparam int END_BYTES     = 4;
    localparam int FRAME_BYTES   = START_BYTES + LED_COUNT * BYTES_PER_LED + END_BYTES;
    localparam int IDX_W         = $clog2(FRAME_BYTES);

    localparam logic [7:0] START_BYTE  = 8'h00;
    localparam logic [7:0] END_BYTE    = 8'hFF;
    localparam logic [7:0] HEADER_BITS = 8'hE0;
    localparam logic [7:0] BRIGHT_MASK = 8'h1F;

    localparam logic [1:0] POS_HEADER = 2'd0;
    localparam logic [1:0] POS_BLUE   = 2'd1;
    localparam logic [1:0] POS_GREEN  = 2'd2;
    localparam logic [1:0] POS_RED    = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // {red, green, blue}
    localparam logic [23:0] COLOUR_TABLE [8] = '{
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
        24'h00FFFF, 24'hFF00FF, 24'hFFFFFF, 24'h000000
    };

    typedef struct packed {
        logic [MASK_W-1:0]   mask;
        logic [COLOUR_W-1:0] colour;
    } frame_entry_t;

    function automatic logic [7:0] frame_byte(
        input logic [IDX_W-1:0]    idx,
        input logic [MASK_W-1:0]   mask,
        input logic [COLOUR_W-1:0] colour
    );
        logic [IDX_W-1:0] rel;
        logic [1:0]       led;
        logic [1:0]       pos;
        logic [23:0]      rgb;
        logic [7:0]       b;
        rel = idx - IDX_W'(START_BYTES);
        led = rel[3:2];
        pos = rel[1:0];
        rgb = COLOUR_TABLE[colour];
        if (idx < IDX_W'(START_BYTES))
            b = START_BYTE;
        else if (idx >= IDX_W'(START_BYTES + LED_COUNT * BYTES_PER_LED))
            b = END_BYTE;
        else begin
            case (pos)
                POS_HEADER: b = HEADER_BITS | ({7'd0, mask[led]} & BRIGHT_MASK);
                POS_BLUE:   b = rgb[7:0];
                POS_GREEN:  b = rgb[15:8];
                POS_RED:    b = rgb[23:16];
                default:    b = START_BYTE;
            endcase
        end
        return b;
    endfunction

endpackage

/* sv/lgf_front.sv */
// Front end: classifies a sample into a bar mask and steps the colour index.
// Depends on lgf_pkg.
module lgf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           pot_sample,
    output logic                 push,
    output lgf_pkg::frame_entry_t entry
);
    import lgf_pkg::*;

    logic [MASK_W-1:0]   prev_mask_reg, prev_mask_next;
    logic [COLOUR_W-1:0] colour_reg, colour_next;
    logic [MASK_W-1:0]   mask;
    logic [COLOUR_W-1:0] stepped;

    always_comb
    begin
        mask[0] = (pot_sample >= LIT0_MIN);
        mask[1] = (pot_sample >= LIT1_MIN);
        mask[2] = (pot_sample == LIT2_MIN);
        // wrap to the first colour at or past the last one
        if (colour_reg >= COLOUR_W'(COLOUR_COUNT - 1))
            stepped = '0;
        else
            stepped = colour_reg + COLOUR_W'(1);
        colour_next    = (mask != prev_mask_reg) ? stepped : colour_reg;
        prev_mask_next = mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mask_reg <= '0;
            colour_reg    <= COLOUR_W'(COLOUR_COUNT - 1);
        end
        else if (accept)
        begin
            prev_mask_reg <= prev_mask_next;
            colour_reg    <= colour_next;
        end
    end

    assign push         = accept;
    assign entry.mask   = mask;
    assign entry.colour = colour_next;

endmodule

/* sv/lgf_queue.sv */
// Short queue of classified frames between front and back end.
// Depends on lgf_pkg.
module lgf_queue (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  lgf_pkg::frame_entry_t     wr_entry,
    input  logic                      pop,
    output lgf_pkg::frame_entry_t     head,
    output logic                      full,
    output logic                      nonempty,
    output logic [lgf_pkg::QLVL_W-1:0] level
);
    import lgf_pkg::*;

    frame_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QLVL_W-1:0]   level_reg, level_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + QLVL_W'(push) - QLVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    assign head     = slot_reg[rd_ptr_reg];
    assign full     = (level_reg == QLVL_W'(QUEUE_DEPTH));
    assign nonempty = (level_reg != '0);
    assign level    = level_reg;

endmodule

/* sv/lgf_back.sv */
// Back end: walks the 20-byte LED stream for the queue head into an output register.
// Depends on lgf_pkg.
module lgf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  nonempty,
    input  lgf_pkg::frame_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            spi_byte,
    output logic                  frame_last
);
    import lgf_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             load;
    logic             at_end;

    always_comb
    begin
        load   = nonempty && (!valid_reg || !out_stall);
        at_end = (idx_reg == IDX_W'(FRAME_BYTES - 1));
        if (load)
            idx_next = at_end ? '0 : idx_reg + IDX_W'(1);
        else
            idx_next = idx_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= frame_byte(idx_reg, head.mask, head.colour);
            last_reg <= at_end;
        end
    end

    // release the queue entry once its final byte is loaded
    assign pop        = load && at_end;
    assign out_valid  = valid_reg;
    assign spi_byte   = byte_reg;
    assign frame_last = last_reg;

endmodule

/* sv/apa102_level_gauge_frame.sv */
// Each accepted sample is classified and queued; the back end registers its 20-byte stream
// one byte per cycle unless out_stall holds it, and that rate bounds the sample throughput;
// a two-entry queue lets samples be taken while a stream is still going out.
// Reset (rst_n, async): previous mask 0, colour index white, queue and output empty.
// Depends on lgf_pkg, lgf_front, lgf_queue, lgf_back.
module apa102_level_gauge_frame (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] pot_sample,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] spi_byte,
    output logic       frame_last
);
    import lgf_pkg::*;

    logic              accept;
    logic              push;
    logic              pop;
    logic              full;
    logic              nonempty;
    logic [QLVL_W-1:0] level;
    frame_entry_t      wr_entry;
    frame_entry_t      head;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    lgf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pot_sample (pot_sample),
        .push       (push),
        .entry      (wr_entry)
    );

    lgf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .nonempty (nonempty),
        .level    (level)
    );

    lgf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .nonempty   (nonempty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .spi_byte   (spi_byte),
        .frame_last (frame_last)
    );

    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> spi_byte == END_BYTE)
        else $error("last byte of a frame is not an end byte");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> level != '0)
        else $error("queue popped while empty");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= QLVL_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> level != '0)
        else $error("pushed transaction lost from queue");

endmodule

/* test/testbench.sv */
// Self-checking bench for apa102_level_gauge_frame: drives potentiometer samples and checks
// every 20-byte LED stream against an in-bench level/colour predictor.
// Depends on lgf_pkg (colour count) and the apa102_level_gauge_frame RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HUE_COUNT   = lgf_pkg::COLOUR_COUNT;
    localparam int RAND_ITEMS  = 360;
    localparam int HOLD_CYCLES = 160;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 30;

    localparam logic [7:0] START_CODE = 8'h00;
    localparam logic [7:0] END_CODE   = 8'hFF;
    localparam logic [7:0] LED_HEAD   = 8'hE0;

    // {red, green, blue}: red, green, blue, yellow, cyan, magenta, white, black
    localparam logic [23:0] HUE_RGB [8] = '{
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
        24'h00FFFF, 24'hFF00FF, 24'hFFFFFF, 24'h000000
    };

    typedef struct packed {
        logic [7:0] sample;
        logic       known;
        logic [2:0] bar;
        logic [2:0] hue;
    } probe_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } spi_beat_t;

    // sample, typed-in flag, bar mask, colour index (after the step)
    localparam int PROBE_ROWS = 19;
    localparam probe_row_t PROBES [PROBE_ROWS] = '{
        '{8'd0,   1'b1, 3'd0, 3'd6},   // reset state: dark, white
        '{8'd255, 1'b1, 3'd7, 3'd0},   // full scale, index wraps from white
        '{8'd255, 1'b1, 3'd7, 3'd0},   // same mask, no step
        '{8'd84,  1'b1, 3'd0, 3'd1},   // just below first threshold
        '{8'd85,  1'b1, 3'd1, 3'd2},   // first threshold
        '{8'd168, 1'b0, 3'd0, 3'd0},
        '{8'd169, 1'b1, 3'd3, 3'd3},   // second threshold
        '{8'd254, 1'b0, 3'd0, 3'd0},
        '{8'd255, 1'b1, 3'd7, 3'd4},
        '{8'd0,   1'b1, 3'd0, 3'd5},
        '{8'd128, 1'b0, 3'd0, 3'd0},
        '{8'd170, 1'b1, 3'd3, 3'd0},   // wrap again past white
        '{8'd1,   1'b0, 3'd0, 3'd0},
        '{8'd170, 1'b0, 3'd0, 3'd0},
        '{8'd85,  1'b0, 3'd0, 3'd0},
        '{8'd127, 1'b0, 3'd0, 3'd0},
        '{8'd128, 1'b0, 3'd0, 3'd0},
        '{8'd254, 1'b0, 3'd0, 3'd0},
        '{8'd1,   1'b0, 3'd0, 3'd0}
    };

    localparam logic [7:0] EDGE_SAMPLES [9] = '{
        8'd0, 8'd84, 8'd85, 8'd86, 8'd168, 8'd169, 8'd170, 8'd254, 8'd255
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] pot_sample = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] spi_byte;
    logic       frame_last;

    spi_beat_t   beat_queue [$];
    logic [2:0]  last_bar = 3'd0;
    logic [2:0]  hue_idx = 3'(HUE_COUNT - 1);
    bit          calm = 1'b0;
    int unsigned hold_ask = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned fails = 0;
    int unsigned samples_sent = 0;
    int unsigned beats_checked = 0;
    int unsigned hue_steps = 0;
    int unsigned quiet_cycles = 0;

    apa102_level_gauge_frame u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pot_sample (pot_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .spi_byte   (spi_byte),
        .frame_last (frame_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [2:0] bar_of(input logic [7:0] sample);
        int unsigned level;
        logic [2:0]  bar;
        level = (int'(sample) * 100) / 255;
        bar = {level == 100, level >= 66, level >= 33};
        return bar;
    endfunction

    task automatic push_frame(input logic [2:0] bar, input logic [2:0] hue);
        logic [23:0] rgb;
        int          n;
        rgb = HUE_RGB[hue];
        for (n = 0; n < 4; n++)
            beat_queue.push_back('{START_CODE, 1'b0});
        for (n = 0; n < 3; n++)
        begin
            beat_queue.push_back('{LED_HEAD | {7'd0, bar[n]}, 1'b0});
            beat_queue.push_back('{rgb[7:0], 1'b0});
            beat_queue.push_back('{rgb[15:8], 1'b0});
            beat_queue.push_back('{rgb[23:16], 1'b0});
        end
        for (n = 0; n < 4; n++)
            beat_queue.push_back('{END_CODE, n == 3});
    endtask

    // Advance the gauge state for one accepted sample and queue its stream.
    task automatic predict_gauge(input probe_row_t row);
        logic [2:0] bar;
        bar = bar_of(row.sample);
        if (bar != last_bar)
        begin
            hue_idx = (int'(hue_idx) >= HUE_COUNT - 1) ? 3'd0 : hue_idx + 3'd1;
            hue_steps++;
        end
        last_bar = bar;
        if (row.known)
            push_frame(row.bar, row.hue);
        else
            push_frame(bar, hue_idx);
        samples_sent++;
    endtask

    // Offer one sample, hold it until taken, then idle at random.
    task automatic send_sample(input probe_row_t row);
        in_valid <= 1'b1;
        pot_sample <= row.sample;
        do
            @(posedge clk);
        while (in_stall);
        predict_gauge(row);
        if (!calm && $urandom_range(0, 99) < 28)
        begin
            in_valid <= 1'b0;
            pot_sample <= 8'($urandom);
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 50);
        end
    endtask

    task automatic drain_frames;
        while (beat_queue.size() != 0)
            @(posedge clk);
    endtask

    // Output side: check each transaction, then choose the next stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (beat_queue.size() == 0)
            begin
                $error("unexpected transaction: spi_byte %h frame_last %b", spi_byte, frame_last);
                fails++;
            end
            else
            begin
                if (spi_byte !== beat_queue[0].data)
                begin
                    $error("spi_byte: expected %h, got %h", beat_queue[0].data, spi_byte);
                    fails++;
                end
                if (frame_last !== beat_queue[0].last)
                begin
                    $error("frame_last: expected %b, got %b", beat_queue[0].last, frame_last);
                    fails++;
                end
                void'(beat_queue.pop_front());
                beats_checked++;
            end
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_ask != hold_seen)
        begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 28);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("[apa102_level_gauge_frame] ERROR");
            $finish;
        end
    end

    initial
    begin
        probe_row_t row;
        int         n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < PROBE_ROWS; n++)
            send_sample(PROBES[n]);

        for (n = 0; n < RAND_ITEMS; n++)
        begin
            calm = (n >= 100 && n < 170);
            if (n == 60)
                hold_ask++;
            if (n == 220)
            begin
                in_valid <= 1'b0;
                drain_frames();
            end
            row = '0;
            if ($urandom_range(0, 99) < 40)
                row.sample = EDGE_SAMPLES[$urandom_range(0, 8)];
            else
                row.sample = 8'($urandom_range(0, 255));
            send_sample(row);
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        drain_frames();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d samples, %0d stream bytes checked, %0d colour steps",
                 samples_sent, beats_checked, hue_steps);
        if (fails == 0)
            $display("[apa102_level_gauge_frame] OK");
        else
            $display("[apa102_level_gauge_frame] ERROR");
        $finish;
    end

endmodule

/* sim.f */
sv/lgf_pkg.sv
sv/lgf_front.sv
sv/lgf_queue.sv
sv/lgf_back.sv
sv/apa102_level_gauge_frame.sv
test/testbench.sv
